/* rtl/core/sdm_pkg.sv */
// Shared widths, register codes and reset values for the step detector.
package sdm_pkg;

  localparam int AXIS_W  = 10;
  localparam int SQ_W    = 19;
  localparam int SUM_W   = 20;
  localparam int MAG_W   = 10;
  localparam int TIME_W  = 32;
  localparam int CNT_W   = 32;
  localparam int ADD_W   = 2;
  localparam int THR_W   = 10;
  localparam int DEB_W   = 16;
  localparam int CFG_AW  = 3;
  localparam int CFG_DW  = 32;

  // Register index, taken from paddr[2]
  localparam logic REG_THRESHOLD = 1'b0;
  localparam logic REG_DEBOUNCE  = 1'b1;

  localparam logic MODE_SAMPLE = 1'b0;
  localparam logic MODE_PULSE  = 1'b1;

  localparam logic [THR_W-1:0] THRESHOLD_RST = THR_W'(26);
  localparam logic [DEB_W-1:0] DEBOUNCE_RST  = DEB_W'(500);

  typedef logic signed [AXIS_W-1:0] axis_t;
  typedef logic [SQ_W-1:0]          square_t;
  typedef logic [MAG_W-1:0]         mag_t;

endpackage

/* rtl/core/sdm_in_if.sv */
// Input channel: accelerometer samples and step-interrupt pulses.
interface sdm_in_if import sdm_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                mode;
  logic [TIME_W-1:0]   time_ms;
  axis_t               accel_x;
  axis_t               accel_y;
  axis_t               accel_z;

  modport source (output valid, mode, time_ms, accel_x, accel_y, accel_z, input ready);
  modport sink   (input valid, mode, time_ms, accel_x, accel_y, accel_z, output ready);
endinterface

/* rtl/core/sdm_out_if.sv */
// Result channel: steps added, running total and magnitude.
interface sdm_out_if import sdm_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [ADD_W-1:0]   steps_added;
  logic [CNT_W-1:0]   step_total;
  mag_t               magnitude;

  modport source (output valid, steps_added, step_total, magnitude, input ready);
  modport sink   (input valid, steps_added, step_total, magnitude, output ready);
endinterface

/* rtl/core/sdm_lane.sv */
// One axis lane: registered square of a signed acceleration component.
module sdm_lane import sdm_pkg::*; (
  input  logic    clk,
  input  logic    load,
  input  axis_t   axis,
  output square_t square
);

  logic signed [2*AXIS_W-1:0] prod;
  square_t                    square_r;

  assign prod   = (2*AXIS_W)'(axis) * (2*AXIS_W)'(axis);
  assign square = square_r;

  always_ff @(posedge clk) begin
    if (load) begin
      square_r <= prod[SQ_W-1:0];
    end
  end

endmodule

/* rtl/core/sdm_isqrt.sv */
// Bit-serial floor square root, one result bit per cycle.
module sdm_isqrt import sdm_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [SUM_W-1:0] radicand,
  output logic             done,
  output mag_t             root
);

  localparam int REM_W  = MAG_W + 2;
  localparam int WORK_W = REM_W + 2;
  localparam int CNT_B  = $clog2(MAG_W);

  logic [SUM_W-1:0]  rad_r;
  logic [REM_W-1:0]  rem_r;
  mag_t              root_r;
  logic [CNT_B-1:0]  cnt_r;
  logic              busy_r;
  logic              done_r;

  logic [WORK_W-1:0] rem_w;
  logic [WORK_W-1:0] trial;
  logic              fits;

  // Bring down the next two radicand bits and try root*4+1
  assign rem_w = {rem_r, rad_r[SUM_W-1 -: 2]};
  assign trial = {{(WORK_W-MAG_W-2){1'b0}}, root_r, 2'b01};
  assign fits  = (rem_w >= trial);

  assign done = done_r;
  assign root = root_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_B'(MAG_W - 1);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNT_B'(1);
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad_r  <= radicand;
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      rad_r  <= {rad_r[SUM_W-3:0], 2'b00};
      rem_r  <= fits ? REM_W'(rem_w - trial) : rem_w[REM_W-1:0];
      root_r <= {root_r[MAG_W-2:0], fits};
    end
  end

endmodule

/* rtl/core/step_detector_magnitude_debounce.sv */
// Pedometer top: axis lanes, serial root, step decision and APB registers.
//
//   channel   dir   handshake      word
//   in_if     in    valid/ready    mode, time_ms, accel_x/y/z
//   out_if    out   valid/ready    steps_added, step_total, magnitude
//   apb       in    psel/penable   step_threshold (0x0), debounce_ms (0x4)
//
// A sample goes through these steps from acceptance to result: squares register
// at acceptance, ST_SUM sums and loads the root unit, ten root iterations, the
// root is handed over, and ST_FIN decides. A pulse goes straight to ST_FIN.
// One item is in flight at a time; the next is accepted the cycle after a result.
// rst_n is synchronous; it clears the registers, the step state and flags.
// A result held by a stalled out_if blocks only the final step of the next item.
module step_detector_magnitude_debounce import sdm_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  sdm_in_if.sink            in_if,
  sdm_out_if.source         out_if,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SUM  = 2'd1;
  localparam logic [1:0] ST_ROOT = 2'd2;
  localparam logic [1:0] ST_FIN  = 2'd3;

  logic [1:0]        state_r, state_nxt;

  logic [THR_W-1:0]  thr_r;
  logic [DEB_W-1:0]  deb_r;

  logic              mode_r;
  logic [TIME_W-1:0] time_r;

  mag_t              prev_mag_r, prev_mag_nxt;
  logic              primed_r, primed_nxt;
  logic              pend_r, pend_nxt;
  logic [TIME_W-1:0] last_pulse_r, last_pulse_nxt;
  logic [TIME_W-1:0] last_mag_r, last_mag_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;

  logic              out_valid_r;
  logic [ADD_W-1:0]  out_added_r, out_added_nxt;
  logic [CNT_W-1:0]  out_total_r;
  mag_t              out_mag_r, out_mag_nxt;

  logic              in_fire, fin_fire, cfg_wr;
  square_t           sq_x, sq_y, sq_z;
  logic [SUM_W-1:0]  sum;
  logic              root_start, root_done;
  mag_t              root;
  mag_t              mag_diff;
  logic [TIME_W-1:0] pulse_gap, mag_gap;
  logic              mag_step;

  assign in_fire  = in_if.valid && in_if.ready;
  assign fin_fire = (state_r == ST_FIN) && (!out_valid_r || out_if.ready);
  assign cfg_wr   = psel && penable && pwrite && pready;

  assign in_if.ready        = (state_r == ST_IDLE);
  assign out_if.valid       = out_valid_r;
  assign out_if.steps_added = out_added_r;
  assign out_if.step_total  = out_total_r;
  assign out_if.magnitude   = out_mag_r;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_THRESHOLD) ? {{(CFG_DW-THR_W){1'b0}}, thr_r}
                                              : {{(CFG_DW-DEB_W){1'b0}}, deb_r};

  sdm_lane u_lane_x (.clk(clk), .load(in_fire), .axis(in_if.accel_x), .square(sq_x));
  sdm_lane u_lane_y (.clk(clk), .load(in_fire), .axis(in_if.accel_y), .square(sq_y));
  sdm_lane u_lane_z (.clk(clk), .load(in_fire), .axis(in_if.accel_z), .square(sq_z));

  // Merge the lanes into the radicand
  assign sum        = SUM_W'(sq_x) + SUM_W'(sq_y) + SUM_W'(sq_z);
  assign root_start = (state_r == ST_SUM);

  sdm_isqrt u_isqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (root_start),
    .radicand (sum),
    .done     (root_done),
    .root     (root)
  );

  assign mag_diff  = (root > prev_mag_r) ? (root - prev_mag_r) : (prev_mag_r - root);
  assign pulse_gap = time_r - last_pulse_r;
  assign mag_gap   = time_r - last_mag_r;
  assign mag_step  = primed_r && (mag_diff > thr_r)
                     && (mag_gap >= {{(TIME_W-DEB_W){1'b0}}, deb_r});

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          state_nxt = (in_if.mode == MODE_PULSE) ? ST_FIN : ST_SUM;
        end
      end
      ST_SUM:  state_nxt = ST_ROOT;
      ST_ROOT: begin
        if (root_done) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (fin_fire) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    prev_mag_nxt   = prev_mag_r;
    primed_nxt     = primed_r;
    pend_nxt       = pend_r;
    last_pulse_nxt = last_pulse_r;
    last_mag_nxt   = last_mag_r;
    out_added_nxt  = '0;
    out_mag_nxt    = '0;
    if (mode_r == MODE_PULSE) begin
      if (pulse_gap >= {{(TIME_W-DEB_W){1'b0}}, deb_r}) begin
        pend_nxt       = 1'b1;
        last_pulse_nxt = time_r;
      end
    end else begin
      out_added_nxt = {1'b0, pend_r} + {1'b0, mag_step};
      out_mag_nxt   = root;
      pend_nxt      = 1'b0;
      prev_mag_nxt  = root;
      primed_nxt    = 1'b1;
      if (mag_step) begin
        last_mag_nxt = time_r;
      end
    end
    cnt_nxt = cnt_r + {{(CNT_W-ADD_W){1'b0}}, out_added_nxt};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      thr_r        <= THRESHOLD_RST;
      deb_r        <= DEBOUNCE_RST;
      prev_mag_r   <= '0;
      primed_r     <= 1'b0;
      pend_r       <= 1'b0;
      last_pulse_r <= '0;
      last_mag_r   <= '0;
      cnt_r        <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr) begin
        if (paddr[2] == REG_THRESHOLD) begin
          thr_r <= pwdata[THR_W-1:0];
        end else begin
          deb_r <= pwdata[DEB_W-1:0];
        end
      end
      if (fin_fire) begin
        prev_mag_r   <= prev_mag_nxt;
        primed_r     <= primed_nxt;
        pend_r       <= pend_nxt;
        last_pulse_r <= last_pulse_nxt;
        last_mag_r   <= last_mag_nxt;
        cnt_r        <= cnt_nxt;
        out_valid_r  <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Hold the item and the result word; no reset needed
  always_ff @(posedge clk) begin
    if (in_fire) begin
      mode_r <= in_if.mode;
      time_r <= in_if.time_ms;
    end
    if (fin_fire) begin
      out_added_r <= out_added_nxt;
      out_total_r <= cnt_nxt;
      out_mag_r   <= out_mag_nxt;
    end
  end

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (state_r != ST_IDLE))
    else $error("accepted word did not leave idle");

  a_root_in_root: assert property (@(posedge clk) disable iff (!rst_n)
    root_done |-> (state_r == ST_ROOT))
    else $error("root finished outside root state");

  a_added_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_added_r != 2'd3))
    else $error("steps added out of range");

  a_pend_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    (fin_fire && (mode_r == MODE_SAMPLE)) |=> !pend_r)
    else $error("pending pulse survived a sample");

  a_pulse_no_mag: assert property (@(posedge clk) disable iff (!rst_n)
    (fin_fire && (mode_r == MODE_PULSE)) |=> (out_mag_r == '0 && out_added_r == '0))
    else $error("pulse result carries steps or magnitude");

endmodule
